// ----- sv/std_normal_cdf_defines.svh -----
// Assertion helpers shared by the Horner, reciprocal and output modules.
// Both expect clk and rst_n in the scope where they are used.
`ifndef STD_NORMAL_CDF_DEFINES_SVH
`define STD_NORMAL_CDF_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define SNCDF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sncdf: assertion failed");

// Next-cycle implication, disabled while reset is held.
`define SNCDF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sncdf: assertion failed");

`endif

// ----- sv/sncdf_pkg.sv -----
package sncdf_pkg;

  localparam int IN_FRAC_BITS  = 16;
  localparam int OUT_FRAC_BITS = 24;

  localparam int PT_W  = 24;
  localparam int OUT_W = OUT_FRAC_BITS + 1;

  // Polynomial in Q34, reciprocal and its powers in Q62.
  localparam int QP    = 34;
  localparam int QR    = 62;
  localparam int ACC_W = QP + 3;
  localparam int MAG_W = IN_FRAC_BITS + 3;
  localparam int R_W   = QR + 1;

  localparam int NH  = 6;
  localparam int NQ  = QR + 1;
  localparam int NSQ = 4;

  localparam logic [31:0] SAT_LIMIT = 32'(64'd8 << IN_FRAC_BITS);

  localparam logic [63:0] DEC_SCALE = 64'd10000000000;

  // Ten-decimal coefficient to Q34, rounded to nearest.
  function automatic logic [ACC_W-1:0] to_q34(input logic [63:0] c);
    return ACC_W'((c * (64'd1 << QP) + DEC_SCALE / 64'd2) / DEC_SCALE);
  endfunction

  localparam logic [ACC_W-1:0] D1 = to_q34(64'd498673470);
  localparam logic [ACC_W-1:0] D2 = to_q34(64'd211410061);
  localparam logic [ACC_W-1:0] D3 = to_q34(64'd32776263);
  localparam logic [ACC_W-1:0] D4 = to_q34(64'd380036);
  localparam logic [ACC_W-1:0] D5 = to_q34(64'd488906);
  localparam logic [ACC_W-1:0] D6 = to_q34(64'd53830);

  localparam logic [ACC_W-1:0] ONE_Q = ACC_W'(64'd1 << QP);

  // Addend of each Horner stage, highest order first.
  localparam logic [ACC_W-1:0] HORN_ADD [NH] = '{D5, D4, D3, D2, D1, ONE_Q};

  typedef struct packed {
    logic vld;
    logic neg;
    logic sat;
  } sncdf_ctl_t;

endpackage

// ----- sv/sncdf_horner.sv -----
`include "std_normal_cdf_defines.svh"

module sncdf_horner (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             adv,
  input  logic                             in_valid,
  input  logic signed [sncdf_pkg::PT_W-1:0] in_point,
  output sncdf_pkg::sncdf_ctl_t            ctl_o,
  output logic [sncdf_pkg::ACC_W-1:0]      p_o
);
  import sncdf_pkg::*;

  localparam int PROD_W = ACC_W + MAG_W;
  localparam logic [PROD_W-1:0] RND = PROD_W'(64'd1 << (IN_FRAC_BITS - 1));

  logic [PT_W-1:0]   mag_full;
  sncdf_ctl_t        ctl_in;
  sncdf_ctl_t        ctl_r   [0:NH];
  logic [ACC_W-1:0]  acc_r   [0:NH];
  logic [MAG_W-1:0]  mag_r   [0:NH-1];
  logic [PROD_W-1:0] prod    [0:NH-1];
  logic [ACC_W-1:0]  acc_nxt [0:NH-1];

  // The most negative point wraps to the unsigned value of its magnitude.
  always_comb begin
    mag_full   = in_point[PT_W-1] ? PT_W'(~in_point + PT_W'(1)) : PT_W'(in_point);
    ctl_in.vld = in_valid;
    ctl_in.neg = in_point[PT_W-1];
    ctl_in.sat = (32'(mag_full) >= SAT_LIMIT);
  end

  // Multiplying by the point and shifting by its fraction bits is the Q34 product.
  always_comb begin
    for (int s = 0; s < NH; s++) begin
      prod[s]    = PROD_W'(acc_r[s]) * PROD_W'(mag_r[s]);
      acc_nxt[s] = ACC_W'((prod[s] + RND) >> IN_FRAC_BITS) + HORN_ADD[s];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= NH; s++) ctl_r[s] <= '0;
    end else if (adv) begin
      ctl_r[0] <= ctl_in;
      for (int s = 0; s < NH; s++) ctl_r[s+1] <= ctl_r[s];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      acc_r[0] <= D6;
      mag_r[0] <= MAG_W'(mag_full);
      for (int s = 0; s < NH; s++) acc_r[s+1] <= acc_nxt[s];
      for (int s = 0; s < NH - 1; s++) mag_r[s+1] <= mag_r[s];
    end
  end

  assign ctl_o = ctl_r[NH];
  assign p_o   = acc_r[NH];

  `SNCDF_ASSERT_IMPL(a_p_floor, ctl_r[NH].vld, acc_r[NH] >= ONE_Q)

endmodule

// ----- sv/sncdf_recip.sv -----
`include "std_normal_cdf_defines.svh"

module sncdf_recip (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  sncdf_pkg::sncdf_ctl_t       ctl_i,
  input  logic [sncdf_pkg::ACC_W-1:0] p_i,
  output sncdf_pkg::sncdf_ctl_t       ctl_o,
  output logic [sncdf_pkg::R_W-1:0]   r_o
);
  import sncdf_pkg::*;

  localparam int REM_W = ACC_W + 1;
  localparam logic [REM_W-1:0] REM_INIT   = REM_W'(64'd1 << QP);
  localparam logic [R_W-1:0]   RECIP_MAX  = R_W'(64'd1 << QR);
  localparam logic [R_W-1:0]   RECIP_MIN  = R_W'(64'd1 << (QR - 3));

  sncdf_ctl_t       ctl_r   [0:NQ-1];
  logic [REM_W-1:0] rem_r   [0:NQ-2];
  logic [ACC_W-1:0] p_r     [0:NQ-2];
  logic [R_W-1:0]   quo_r   [0:NQ-1];

  logic [REM_W-1:0] rem_in  [0:NQ-1];
  logic [ACC_W-1:0] p_in    [0:NQ-1];
  logic [R_W-1:0]   quo_in  [0:NQ-1];
  logic             ge      [0:NQ-1];
  logic [REM_W-1:0] rem_nxt [0:NQ-2];
  logic [R_W-1:0]   quo_nxt [0:NQ-1];

  // One quotient bit per stage. The remainder is carried already doubled,
  // and it stays below twice the divisor, so one subtraction suffices.
  always_comb begin
    rem_in[0] = REM_INIT;
    p_in[0]   = p_i;
    quo_in[0] = '0;
    for (int j = 1; j < NQ; j++) begin
      rem_in[j] = rem_r[j-1];
      p_in[j]   = p_r[j-1];
      quo_in[j] = quo_r[j-1];
    end
    for (int j = 0; j < NQ; j++) begin
      ge[j]      = (rem_in[j] >= REM_W'(p_in[j]));
      quo_nxt[j] = {quo_in[j][R_W-2:0], ge[j]};
    end
    for (int j = 0; j < NQ - 1; j++) begin
      rem_nxt[j] = ge[j] ? ((rem_in[j] - REM_W'(p_in[j])) << 1) : (rem_in[j] << 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NQ; j++) ctl_r[j] <= '0;
    end else if (adv) begin
      ctl_r[0] <= ctl_i;
      for (int j = 1; j < NQ; j++) ctl_r[j] <= ctl_r[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < NQ; j++) quo_r[j] <= quo_nxt[j];
      for (int j = 0; j < NQ - 1; j++) begin
        rem_r[j] <= rem_nxt[j];
        p_r[j]   <= p_in[j];
      end
    end
  end

  assign ctl_o = ctl_r[NQ-1];
  assign r_o   = quo_r[NQ-1];

  // The divisor lies in [1, 8), so the reciprocal lies in (1/8, 1].
  `SNCDF_ASSERT_IMPL(a_recip_floor, ctl_r[NQ-1].vld, quo_r[NQ-1] >= RECIP_MIN)
  `SNCDF_ASSERT_IMPL(a_recip_ceil, ctl_r[NQ-1].vld, quo_r[NQ-1] <= RECIP_MAX)

endmodule

// ----- sv/sncdf_pow16.sv -----
module sncdf_pow16 (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  sncdf_pkg::sncdf_ctl_t     ctl_i,
  input  logic [sncdf_pkg::R_W-1:0] r_i,
  output sncdf_pkg::sncdf_ctl_t     ctl_o,
  output logic [sncdf_pkg::R_W-1:0] r_o
);
  import sncdf_pkg::*;

  localparam int HALF_W  = 32;
  localparam int HI_W    = R_W - HALF_W;
  localparam int PP_W    = 2 * HALF_W;
  localparam int ACC_A_W = PP_W + 1;
  localparam int ACC_B_W = HI_W + 2 * HALF_W + 2;
  localparam int TOT_W   = 2 * QR + 1;
  localparam logic [ACC_A_W-1:0] RND_A = ACC_A_W'(64'd1 << (QR - 1));

  sncdf_ctl_t         ctl_a_r   [0:NSQ-1];
  sncdf_ctl_t         ctl_b_r   [0:NSQ-1];
  sncdf_ctl_t         ctl_c_r   [0:NSQ-1];
  logic [R_W-1:0]     ra_r      [0:NSQ-1];
  logic [HI_W-1:0]    rb_hi_r   [0:NSQ-1];
  logic [ACC_A_W-1:0] acc_a_r   [0:NSQ-1];
  logic [ACC_B_W-1:0] acc_b_r   [0:NSQ-1];
  logic [R_W-1:0]     res_r     [0:NSQ-1];

  sncdf_ctl_t         ctl_in    [0:NSQ-1];
  logic [R_W-1:0]     sq_in     [0:NSQ-1];
  logic [PP_W-1:0]    bb        [0:NSQ-1];
  logic [PP_W-1:0]    ab        [0:NSQ-1];
  logic [PP_W-1:0]    aa        [0:NSQ-1];
  logic [ACC_A_W-1:0] acc_a_nxt [0:NSQ-1];
  logic [ACC_B_W-1:0] acc_b_nxt [0:NSQ-1];
  logic [TOT_W-1:0]   tot       [0:NSQ-1];

  // Each squaring takes three stages, one 32-bit partial product in each:
  // low times low with the rounding constant, then the cross term, then
  // high times high with the final shift to Q62.
  always_comb begin
    sq_in[0]  = r_i;
    ctl_in[0] = ctl_i;
    for (int k = 1; k < NSQ; k++) begin
      sq_in[k]  = res_r[k-1];
      ctl_in[k] = ctl_c_r[k-1];
    end
    for (int k = 0; k < NSQ; k++) begin
      bb[k]        = PP_W'(sq_in[k][HALF_W-1:0]) * PP_W'(sq_in[k][HALF_W-1:0]);
      acc_a_nxt[k] = ACC_A_W'(bb[k]) + RND_A;
      ab[k]        = PP_W'(ra_r[k][R_W-1:HALF_W]) * PP_W'(ra_r[k][HALF_W-1:0]);
      acc_b_nxt[k] = ACC_B_W'(acc_a_r[k]) + (ACC_B_W'(ab[k]) << (HALF_W + 1));
      aa[k]        = PP_W'(rb_hi_r[k]) * PP_W'(rb_hi_r[k]);
      tot[k]       = TOT_W'(acc_b_r[k]) + (TOT_W'(aa[k]) << PP_W);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NSQ; k++) begin
        ctl_a_r[k] <= '0;
        ctl_b_r[k] <= '0;
        ctl_c_r[k] <= '0;
      end
    end else if (adv) begin
      for (int k = 0; k < NSQ; k++) begin
        ctl_a_r[k] <= ctl_in[k];
        ctl_b_r[k] <= ctl_a_r[k];
        ctl_c_r[k] <= ctl_b_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NSQ; k++) begin
        ra_r[k]    <= sq_in[k];
        acc_a_r[k] <= acc_a_nxt[k];
        rb_hi_r[k] <= ra_r[k][R_W-1:HALF_W];
        acc_b_r[k] <= acc_b_nxt[k];
        res_r[k]   <= tot[k][TOT_W-1:QR];
      end
    end
  end

  assign ctl_o = ctl_c_r[NSQ-1];
  assign r_o   = res_r[NSQ-1];

endmodule

// ----- sv/sncdf_out.sv -----
`include "std_normal_cdf_defines.svh"

module sncdf_out (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sncdf_pkg::sncdf_ctl_t       ctl_i,
  input  logic [sncdf_pkg::R_W-1:0]   r_i,
  output logic                        adv_o,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [sncdf_pkg::OUT_W-1:0] out_probability
);
  import sncdf_pkg::*;

  localparam int SH = QR + 1 - OUT_FRAC_BITS;
  localparam logic [OUT_W-1:0] ONE_OUT = OUT_W'(64'd1 << OUT_FRAC_BITS);
  localparam logic [R_W:0]     RND_T   = (R_W + 1)'(64'd1 << (SH - 1));

  logic [R_W:0]     rsum;
  logic [OUT_W-1:0] tail_raw;
  logic [OUT_W-1:0] tail;
  logic [OUT_W-1:0] res_c;
  logic             take;
  logic             fire;

  logic             out_vld_r,  out_vld_nxt;
  logic [OUT_W-1:0] out_prob_r, out_prob_nxt;
  logic             skid_vld_r,  skid_vld_nxt;
  logic [OUT_W-1:0] skid_prob_r, skid_prob_nxt;

  // Half of the sixteenth power, rounded to the output fraction bits.
  always_comb begin
    rsum     = (R_W + 1)'(r_i) + RND_T;
    tail_raw = rsum[R_W:SH];
    tail     = (tail_raw > ONE_OUT) ? ONE_OUT : tail_raw;
    priority if (ctl_i.sat) begin
      res_c = ctl_i.neg ? '0 : ONE_OUT;
    end else if (ctl_i.neg) begin
      res_c = tail;
    end else begin
      res_c = ONE_OUT - tail;
    end
  end

  // The pipeline runs while the skid register is empty, so a result that
  // leaves the last stage always has somewhere to go.
  assign adv_o = !skid_vld_r;
  assign take  = adv_o && ctl_i.vld;
  assign fire  = out_vld_r && out_ready;

  always_comb begin
    out_vld_nxt   = out_vld_r;
    out_prob_nxt  = out_prob_r;
    skid_vld_nxt  = skid_vld_r;
    skid_prob_nxt = skid_prob_r;
    priority if (skid_vld_r) begin
      if (fire) begin
        out_prob_nxt = skid_prob_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (take) begin
      if (!out_vld_r || fire) begin
        out_vld_nxt  = 1'b1;
        out_prob_nxt = res_c;
      end else begin
        skid_vld_nxt  = 1'b1;
        skid_prob_nxt = res_c;
      end
    end else begin
      if (fire) begin
        out_vld_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_prob_r  <= out_prob_nxt;
    skid_prob_r <= skid_prob_nxt;
  end

  assign out_valid       = out_vld_r;
  assign out_probability = out_prob_r;

  `SNCDF_ASSERT_IMPL(a_skid_behind_out, skid_vld_r, out_vld_r)
  `SNCDF_ASSERT_NEXT(a_skid_catch, take && out_vld_r && !out_ready, skid_vld_r && skid_prob_r == $past(res_c))
  `SNCDF_ASSERT_IMPL(a_prob_range, out_vld_r, out_prob_r <= ONE_OUT)

endmodule

// ----- sv/std_normal_cdf.sv -----
// Channel   Handshake               Payload
// input     in_valid / in_ready     in_point, signed, 16 fraction bits
// result    out_valid / out_ready   out_probability, unsigned, 24 fraction bits
//
// One point is taken in every cycle while in_ready is high. The pipeline holds the
// six Horner stages, the 63 one-bit stages of the reciprocal divider and the twelve
// stages of the four squarings.
// Reset clears the valid bits of every stage and of the output and skid registers.
// A stalled result moves into the skid register; the whole pipeline then holds until
// the output register is taken, and in_ready is low for that time.

module std_normal_cdf (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [sncdf_pkg::PT_W-1:0] in_point,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sncdf_pkg::OUT_W-1:0]       out_probability
);
  import sncdf_pkg::*;

  logic             adv;
  sncdf_ctl_t       ctl_h;
  sncdf_ctl_t       ctl_q;
  sncdf_ctl_t       ctl_s;
  logic [ACC_W-1:0] p_h;
  logic [R_W-1:0]   r_q;
  logic [R_W-1:0]   r_s;

  assign in_ready = adv;

  sncdf_horner u_horner (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_valid),
    .in_point (in_point),
    .ctl_o    (ctl_h),
    .p_o      (p_h)
  );

  sncdf_recip u_recip (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .ctl_i (ctl_h),
    .p_i   (p_h),
    .ctl_o (ctl_q),
    .r_o   (r_q)
  );

  sncdf_pow16 u_pow16 (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .ctl_i (ctl_q),
    .r_i   (r_q),
    .ctl_o (ctl_s),
    .r_o   (r_s)
  );

  sncdf_out u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl_i           (ctl_s),
    .r_i             (r_s),
    .adv_o           (adv),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_probability (out_probability)
  );

endmodule

// ----- bench/std_normal_cdf_tb.sv -----
`timescale 1ns / 100ps

// Holds the distribution values expected from accepted points, oldest first,
// and compares each delivered probability against them.
class cdf_scoreboard;

  localparam int POLY_FRAC  = 34;
  localparam int RECIP_FRAC = 62;
  localparam int RECIP_BITS = 62;
  localparam int SQUARINGS  = 4;

  logic [63:0]                     horner_coef [6];
  logic [sncdf_pkg::OUT_W-1:0]     expected_probs [$];
  int                              failures;
  int                              results_seen;

  function new();
    horner_coef[0] = dec_to_q34(64'd498673470);
    horner_coef[1] = dec_to_q34(64'd211410061);
    horner_coef[2] = dec_to_q34(64'd32776263);
    horner_coef[3] = dec_to_q34(64'd380036);
    horner_coef[4] = dec_to_q34(64'd488906);
    horner_coef[5] = dec_to_q34(64'd53830);
    failures       = 0;
    results_seen   = 0;
  endfunction

  static function logic [63:0] dec_to_q34(input logic [63:0] dec);
    return (dec * (64'd1 << POLY_FRAC) + 64'd5000000000) / 64'd10000000000;
  endfunction

  // Full product, rounded half up, then scaled down by 2^shift.
  static function logic [63:0] scaled_product(input logic [63:0] a, input logic [63:0] b,
                                              input int shift);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    prod = prod + (128'd1 << (shift - 1));
    return 64'(prod >> shift);
  endfunction

  function logic [sncdf_pkg::OUT_W-1:0] cdf_of_point(input logic signed [sncdf_pkg::PT_W-1:0] pt);
    logic        neg;
    logic [24:0] mag;
    logic [63:0] z;
    logic [63:0] acc;
    logic [63:0] p;
    logic [63:0] rem;
    logic [63:0] recip;
    logic [63:0] tail;
    logic [63:0] one_out;
    one_out = 64'd1 << sncdf_pkg::OUT_FRAC_BITS;
    neg     = pt[sncdf_pkg::PT_W-1];
    // Negation in 25 bits also gives the most negative point its full magnitude.
    mag     = neg ? (25'h1000000 - {1'b0, pt}) : {1'b0, pt};
    if (mag >= (25'd8 << sncdf_pkg::IN_FRAC_BITS))
      return neg ? '0 : sncdf_pkg::OUT_W'(one_out);
    z   = 64'(mag) << (POLY_FRAC - sncdf_pkg::IN_FRAC_BITS);
    acc = horner_coef[5];
    for (int k = 4; k >= 0; k--)
      acc = scaled_product(acc, z, POLY_FRAC) + horner_coef[k];
    p = scaled_product(acc, z, POLY_FRAC) + (64'd1 << POLY_FRAC);
    rem   = 64'd1 << POLY_FRAC;
    recip = 64'd0;
    if (rem >= p) begin
      rem   = rem - p;
      recip = 64'd1;
    end
    for (int i = 0; i < RECIP_BITS; i++) begin
      rem   = rem << 1;
      recip = recip << 1;
      if (rem >= p) begin
        rem   = rem - p;
        recip = recip | 64'd1;
      end
    end
    for (int i = 0; i < SQUARINGS; i++)
      recip = scaled_product(recip, recip, RECIP_FRAC);
    tail = (recip + (64'd1 << (RECIP_FRAC - sncdf_pkg::OUT_FRAC_BITS)))
           >> (RECIP_FRAC + 1 - sncdf_pkg::OUT_FRAC_BITS);
    if (tail > one_out)
      tail = one_out;
    return sncdf_pkg::OUT_W'(neg ? tail : (one_out - tail));
  endfunction

  function void note_point(input logic signed [sncdf_pkg::PT_W-1:0] pt);
    expected_probs.push_back(cdf_of_point(pt));
  endfunction

  function void check_probability(input logic [sncdf_pkg::OUT_W-1:0] got);
    logic [sncdf_pkg::OUT_W-1:0] want;
    results_seen++;
    if (expected_probs.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("unexpected result: probability %0d with nothing outstanding", got);
      return;
    end
    want = expected_probs.pop_front();
    if (want !== got) begin
      failures++;
      if (failures <= 10)
        $display("result %0d: probability expected %0d, got %0d", results_seen, want, got);
    end
  endfunction

  function int pending();
    return expected_probs.size();
  endfunction

endclass

module std_normal_cdf_tb;

  import sncdf_pkg::*;

  localparam int RANDOM_POINTS = 1900;
  localparam int DRAIN_CYCLES  = 200;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AFTER    = 300;

  logic                    clk             = 1'b0;
  logic                    rst_n           = 1'b0;
  logic                    in_valid        = 1'b0;
  logic                    in_ready;
  logic signed [PT_W-1:0]  in_point        = '0;
  logic                    out_valid;
  logic                    out_ready       = 1'b0;
  logic [OUT_W-1:0]        out_probability;

  cdf_scoreboard sb;
  bit            quiet_mode = 1'b0;

  std_normal_cdf uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_point        (in_point),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_probability (out_probability)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly no gap, some short ones, a few long ones; none at all in quiet stretches.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_mode || r < 60)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [PT_W-1:0] random_point();
    int          r;
    logic [23:0] mag;
    r = $urandom_range(0, 99);
    if (r < 15)
      return PT_W'($urandom);
    if (r < 25)
      mag = 24'($urandom_range(524280, 524295));
    else
      mag = 24'($urandom_range(0, 524287));
    return $urandom_range(0, 1) ? -$signed(mag) : $signed(mag);
  endfunction

  task automatic send_point(input logic signed [PT_W-1:0] pt);
    int gap;
    in_valid <= 1'b1;
    in_point <= pt;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    sb.note_point(pt);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Result side: random stalls, plus one long hold-off so that the pipeline
  // fills and pushes back on the input.
  initial begin : result_sink
    int  stall_left;
    int  hold_left;
    bit  held_once;
    bit  next_ready;
    stall_left = 0;
    hold_left  = 0;
    held_once  = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        sb.check_probability(out_probability);
      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else if (!held_once && sb.results_seen >= HOLD_AFTER) begin
        held_once  = 1'b1;
        hold_left  = HOLD_CYCLES - 1;
        next_ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        next_ready = 1'b0;
      end else begin
        stall_left = pick_gap();
        next_ready = (stall_left == 0);
        if (stall_left > 0)
          stall_left--;
      end
      out_ready <= next_ready;
    end
  end

  initial begin : stimulus
    logic signed [PT_W-1:0] directed [$];
    sb = new();
    directed = '{24'sd0, 24'sd1, -24'sd1, 24'sd8388607, -24'sd8388608,
                 24'sd524288, -24'sd524288, 24'sd524287, -24'sd524287,
                 24'sd524289, -24'sd524289, 24'sd65536, -24'sd65536,
                 24'sd163840, -24'sd163840, 24'sd32768, -24'sd32768,
                 24'sd262144, -24'sd262144, 24'sd400000, -24'sd400000,
                 24'sd1048576, -24'sd1048576, 24'sd2, -24'sd2};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i])
      send_point(directed[i]);
    for (int n = 0; n < RANDOM_POINTS; n++) begin
      quiet_mode = (n % 400) >= 300;
      send_point(random_point());
    end
    quiet_mode = 1'b0;
    in_valid <= 1'b0;
    while (sb.pending() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/sncdf_pkg.sv
sv/sncdf_horner.sv
sv/sncdf_recip.sv
sv/sncdf_pow16.sv
sv/sncdf_out.sv
sv/std_normal_cdf.sv
bench/std_normal_cdf_tb.sv
